FILE: hdl/lrukv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lrukv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
  } lrukv_cmd_t;

endpackage

FILE: hdl/lrukv_ctrl.sv
// Sequencer for the LRU cache: load, lookup, update, respond.
module lrukv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output lrukv_pkg::lrukv_cmd_t cmd
);
  import lrukv_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_LOOKUP  = 2'd1;
  localparam logic [1:0] ST_UPDATE  = 2'd2;
  localparam logic [1:0] ST_RESPOND = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign busy      = state_r inside {ST_LOOKUP, ST_UPDATE};
  assign out_valid = (state_r == ST_RESPOND);

  assign cmd.load   = start && !busy;
  assign cmd.lookup = (state_r == ST_LOOKUP);
  assign cmd.update = (state_r == ST_UPDATE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP:  state_nxt = ST_UPDATE;
      ST_UPDATE:  state_nxt = ST_RESPOND;
      ST_RESPOND: begin
        state_nxt = start ? ST_LOOKUP : ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: hdl/lrukv_dp.sv
// Datapath for the LRU cache: key CAM, value memory, recency ranks, counters.
module lrukv_dp #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lrukv_pkg::lrukv_cmd_t     cmd,
  input  lrukv_pkg::in_item_t       in_item,
  input  logic [lrukv_pkg::CAP_W-1:0] cap,
  output lrukv_pkg::out_item_t      out_item
);
  import lrukv_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = IW;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > CAP_W) ? FW : CAP_W;

  in_item_t         item_r;
  logic [KEY_W-1:0] key_r  [DEPTH];
  logic [VAL_W-1:0] vmem   [DEPTH];
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [RW-1:0]    rank_r [DEPTH];
  logic [RW-1:0]    rank_nxt [DEPTH];
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0] hits_r, misses_r;

  logic             hit_r, evict_r, free_found_r;
  logic [IW-1:0]    hit_idx_r, vic_idx_r, free_idx_r;
  logic [RW-1:0]    hit_rank_r;
  logic [VAL_W-1:0] rdata_r;
  logic             found_r, get_hit_r;

  logic             hit_c, free_found_c, evict_c;
  logic [IW-1:0]    hit_idx_c, vic_idx_c, free_idx_c;
  logic [RW-1:0]    hit_rank_c;
  logic [CW-1:0]    cap_x, cap_eff, fill_x;

  logic             is_put, insert;
  logic [IW-1:0]    slot, mem_addr;

  // lookup: parallel compare, lowest index wins
  always_comb begin
    hit_c        = 1'b0;
    hit_idx_c    = '0;
    hit_rank_c   = '0;
    vic_idx_c    = '0;
    free_found_c = 1'b0;
    free_idx_c   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == item_r.key) begin
        hit_c      = 1'b1;
        hit_idx_c  = IW'(i);
        hit_rank_c = rank_r[i];
      end
      if (valid_r[i] && FW'(rank_r[i]) == fill_r - FW'(1)) vic_idx_c = IW'(i);
      if (!valid_r[i]) begin
        free_found_c = 1'b1;
        free_idx_c   = IW'(i);
      end
    end
  end

  assign cap_x   = CW'(cap);
  assign cap_eff = (cap_x == '0) ? CW'(1) : ((cap_x > CW'(DEPTH)) ? CW'(DEPTH) : cap_x);
  assign fill_x  = CW'(fill_r);
  assign evict_c = (fill_x >= cap_eff) && (fill_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.lookup) begin
      hit_r        <= hit_c;
      hit_idx_r    <= hit_idx_c;
      hit_rank_r   <= hit_rank_c;
      vic_idx_r    <= vic_idx_c;
      evict_r      <= evict_c;
      free_found_r <= free_found_c;
      free_idx_r   <= free_idx_c;
    end
  end

  // update
  assign is_put   = (item_r.operation == OP_PUT);
  assign insert   = is_put && !hit_r;
  assign slot     = (evict_r && (!free_found_r || vic_idx_r < free_idx_r)) ? vic_idx_r
                                                                           : free_idx_r;
  assign mem_addr = insert ? slot : hit_idx_r;

  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < DEPTH; i++) rank_nxt[i] = rank_r[i];
    if (cmd.update) begin
      if (hit_r) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_r[i] && rank_r[i] < hit_rank_r) rank_nxt[i] = rank_r[i] + RW'(1);
        end
        rank_nxt[hit_idx_r] = '0;
      end else if (is_put) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_r[i] && !(evict_r && IW'(i) == vic_idx_r))
            rank_nxt[i] = rank_r[i] + RW'(1);
        end
        if (evict_r) begin
          valid_nxt[vic_idx_r] = 1'b0;
          rank_nxt[vic_idx_r]  = '0;
        end
        valid_nxt[slot] = 1'b1;
        rank_nxt[slot]  = '0;
        fill_nxt        = evict_r ? fill_r : fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fill_r   <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      for (int i = 0; i < DEPTH; i++) rank_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      for (int i = 0; i < DEPTH; i++) rank_r[i] <= rank_nxt[i];
      if (cmd.update && !is_put) begin
        if (hit_r) hits_r <= (hits_r == '1) ? hits_r : hits_r + CNT_W'(1);
        else       misses_r <= (misses_r == '1) ? misses_r : misses_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (insert) key_r[slot] <= item_r.key;
      if (is_put) vmem[mem_addr] <= item_r.value;
      rdata_r   <= vmem[mem_addr];
      found_r   <= hit_r;
      get_hit_r <= hit_r && !is_put;
    end
  end

  assign out_item.found      = found_r;
  assign out_item.read_value = get_hit_r ? rdata_r : '0;
  assign out_item.hit_count  = hits_r;
  assign out_item.miss_count = misses_r;

endmodule

FILE: hdl/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
//
//  channel  ports                        handshake
//  input    start, busy, in_item         taken when start && !busy
//  result   out_valid, out_item          one-cycle strobe, no back-pressure
//  config   cfg_we, cfg_wdata            capacity written when cfg_we
//
// An item passes the lookup register stage, then the update with value memory read,
// then the result strobe. The next item may be accepted in the result cycle, but
// not while the block is busy with the last one.
// Synchronous reset clears valid marks, ranks, fill level and counters and sets
// capacity to 16; no clearing pass. The receiver cannot stall the result.
module lru_key_value_cache_unit #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lrukv_pkg::in_item_t         in_item,
  output logic                        out_valid,
  output lrukv_pkg::out_item_t        out_item,
  input  logic                        cfg_we,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_wdata
);
  import lrukv_pkg::*;

  logic [CAP_W-1:0] cap_r;
  lrukv_cmd_t       cmd;

  always_ff @(posedge clk) begin
    if (!rst_n)      cap_r <= CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  lrukv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lrukv_dp #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cap      (cap_r),
    .out_item (out_item)
  );

endmodule

FILE: hdl/lrukv_checker.sv
// Port-level checks for the LRU cache, bound to the top level.
module lrukv_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input lrukv_pkg::out_item_t out_item
);
  import lrukv_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after item accepted");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("result not strobed three cycles after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid || $past(start))
    else $error("result strobe held without new item");

  a_not_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy during result cycle");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.read_value == '0)
    else $error("nonzero read value without hit");

endmodule

bind lru_key_value_cache_unit lrukv_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
